// ----- src/ffsa_pkg.sv -----
// ---------------------------------------------------------------------------
// ffsa_pkg
// Types and constants for the first-fit segment allocator.
// ---------------------------------------------------------------------------
package ffsa_pkg;

   localparam int MEM_UNITS    = 65536;
   localparam int MAX_SEGMENTS = 32;
   localparam int IDX_W        = $clog2(MAX_SEGMENTS);
   localparam int CNT_W        = IDX_W + 1;
   localparam int ADDR_W       = 16;
   localparam int LEN_W        = 17;
   localparam int JOB_W        = 8;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_NOFIT = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic             kind;
      logic [JOB_W-1:0] job;
      logic [LEN_W-1:0] request_size;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] granted_start;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SPLIT,
      ST_PREV,
      ST_NEXT,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CLAIM,
      OP_RELEASE,
      OP_SPLIT,
      OP_MERGE
   } tbl_op_type;

endpackage

// ----- src/first_fit_segment_allocator.sv -----
// From accept to result valid: an exact-fit allocate scans the table up to the first hit and
// finishes; a split adds a split step; a failed search scans every entry (at most 32);
// a free scans, then checks the previous and next entries for merges; a zero-size allocate goes
// straight to finish. A result held by rsp_ready stalls the finish step. One item at a time;
// ready returns the cycle after the result loads.
// Reset: the table holds one free segment covering all of memory, no result pending.
// ---------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit allocator over an address-ordered segment table with coalescing.
// ---------------------------------------------------------------------------
module first_fit_segment_allocator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ffsa_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ffsa_pkg::rsp_type rsp_item
);

   localparam int NSEG = ffsa_pkg::MAX_SEGMENTS;
   localparam int IW   = ffsa_pkg::IDX_W;
   localparam int CW   = ffsa_pkg::CNT_W;
   localparam int AW   = ffsa_pkg::ADDR_W;
   localparam int LW   = ffsa_pkg::LEN_W;
   localparam int JW   = ffsa_pkg::JOB_W;

   ffsa_pkg::state_type  state_ff, state_in;
   ffsa_pkg::tbl_op_type op;
   ffsa_pkg::req_type    req_ff;
   ffsa_pkg::rsp_type    res_ff, res_in;
   ffsa_pkg::rsp_type    rsp_ff;
   logic                 rsp_valid_ff;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        count_ff;
   logic [AW-1:0]        cur_start_ff, cur_start_in;
   logic [LW-1:0]        cur_len_ff, cur_len_in;

   logic [AW-1:0]        start_ff [NSEG];
   logic [LW-1:0]        len_ff   [NSEG];
   logic                 free_ff  [NSEG];
   logic [JW-1:0]        owner_ff [NSEG];

   logic [IW-1:0]        rd_addr;
   logic [AW-1:0]        rd_start;
   logic [LW-1:0]        rd_len;
   logic                 rd_free;
   logic [JW-1:0]        rd_owner;
   logic [CW-1:0]        wr_idx;
   logic [CW-1:0]        rm_idx;
   logic [LW-1:0]        new_len;
   logic                 hit;
   logic                 load_rsp;

   assign req_ready = (state_ff == ffsa_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      unique case (state_ff)
         ffsa_pkg::ST_PREV: rd_addr = idx_ff[IW-1:0] - IW'(1);
         ffsa_pkg::ST_NEXT: rd_addr = idx_ff[IW-1:0] + IW'(1);
         default:           rd_addr = idx_ff[IW-1:0];
      endcase
   end

   assign rd_start = start_ff[rd_addr];
   assign rd_len   = len_ff[rd_addr];
   assign rd_free  = free_ff[rd_addr];
   assign rd_owner = owner_ff[rd_addr];

   always_comb begin
      if (req_ff.kind == ffsa_pkg::KIND_ALLOC) begin
         hit = rd_free && (rd_len >= req_ff.request_size);
      end else begin
         hit = !rd_free && (rd_owner == req_ff.job);
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cur_start_in = cur_start_ff;
      cur_len_in   = cur_len_ff;
      res_in       = res_ff;
      op           = ffsa_pkg::OP_NONE;
      wr_idx       = idx_ff;
      rm_idx       = idx_ff + CW'(1);
      new_len      = '0;
      load_rsp     = 1'b0;
      unique case (state_ff)
         ffsa_pkg::ST_IDLE: begin
            if (req_valid) begin
               idx_in = '0;
               res_in = '{status: ffsa_pkg::STATUS_NOFIT, granted_start: '0};
               if (req_item.kind == ffsa_pkg::KIND_ALLOC && req_item.request_size == '0) begin
                  state_in = ffsa_pkg::ST_FINISH;
               end else begin
                  state_in = ffsa_pkg::ST_SCAN;
               end
            end
         end
         ffsa_pkg::ST_SCAN: begin
            if (idx_ff == count_ff) begin
               res_in   = '{status: ffsa_pkg::STATUS_NOFIT, granted_start: '0};
               state_in = ffsa_pkg::ST_FINISH;
            end else if (hit) begin
               cur_start_in = rd_start;
               cur_len_in   = rd_len;
               if (req_ff.kind == ffsa_pkg::KIND_FREE) begin
                  op       = ffsa_pkg::OP_RELEASE;
                  state_in = ffsa_pkg::ST_PREV;
               end else if (rd_len == req_ff.request_size) begin
                  op       = ffsa_pkg::OP_CLAIM;
                  res_in   = '{status: ffsa_pkg::STATUS_OK, granted_start: rd_start};
                  state_in = ffsa_pkg::ST_FINISH;
               end else if (count_ff == CW'(NSEG)) begin
                  res_in   = '{status: ffsa_pkg::STATUS_FULL, granted_start: '0};
                  state_in = ffsa_pkg::ST_FINISH;
               end else begin
                  state_in = ffsa_pkg::ST_SPLIT;
               end
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ffsa_pkg::ST_SPLIT: begin
            op       = ffsa_pkg::OP_SPLIT;
            res_in   = '{status: ffsa_pkg::STATUS_OK, granted_start: cur_start_ff};
            state_in = ffsa_pkg::ST_FINISH;
         end
         ffsa_pkg::ST_PREV: begin
            if (idx_ff != '0 && rd_free &&
                ({2'b0, rd_start} + {1'b0, rd_len}) == {2'b0, cur_start_ff}) begin
               op           = ffsa_pkg::OP_MERGE;
               wr_idx       = idx_ff - CW'(1);
               rm_idx       = idx_ff;
               new_len      = rd_len + cur_len_ff;
               idx_in       = idx_ff - CW'(1);
               cur_start_in = rd_start;
               cur_len_in   = new_len;
            end
            state_in = ffsa_pkg::ST_NEXT;
         end
         ffsa_pkg::ST_NEXT: begin
            if ((idx_ff + CW'(1)) < count_ff && rd_free &&
                ({2'b0, cur_start_ff} + {1'b0, cur_len_ff}) == {2'b0, rd_start}) begin
               op      = ffsa_pkg::OP_MERGE;
               wr_idx  = idx_ff;
               rm_idx  = idx_ff + CW'(1);
               new_len = cur_len_ff + rd_len;
            end
            res_in   = '{status: ffsa_pkg::STATUS_OK, granted_start: '0};
            state_in = ffsa_pkg::ST_FINISH;
         end
         ffsa_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = ffsa_pkg::ST_IDLE;
            end
         end
         default: state_in = ffsa_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffsa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= CW'(1);
      end else begin
         state_ff <= state_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (op == ffsa_pkg::OP_SPLIT) begin
            count_ff <= count_ff + CW'(1);
         end else if (op == ffsa_pkg::OP_MERGE) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      cur_start_ff <= cur_start_in;
      cur_len_ff   <= cur_len_in;
      res_ff       <= res_in;
      if (req_valid && req_ready) begin
         req_ff <= req_item;
      end
      if (load_rsp) begin
         rsp_ff <= res_ff;
      end
   end

   for (genvar k = 0; k < NSEG; k++) begin : g_entry
      localparam int KP = (k == 0) ? 0 : k - 1;
      localparam int KN = (k == NSEG - 1) ? k : k + 1;
      always_ff @(posedge clock) begin
         if (reset) begin
            free_ff[k]  <= (k == 0);
            start_ff[k] <= '0;
            len_ff[k]   <= (k == 0) ? LW'(ffsa_pkg::MEM_UNITS) : '0;
         end else begin
            unique case (op)
               ffsa_pkg::OP_CLAIM: begin
                  if (CW'(k) == idx_ff) begin
                     free_ff[k]  <= 1'b0;
                     owner_ff[k] <= req_ff.job;
                  end
               end
               ffsa_pkg::OP_RELEASE: begin
                  if (CW'(k) == idx_ff) begin
                     free_ff[k]  <= 1'b1;
                     owner_ff[k] <= '0;
                  end
               end
               ffsa_pkg::OP_SPLIT: begin
                  if (CW'(k) == idx_ff) begin
                     len_ff[k]   <= req_ff.request_size;
                     free_ff[k]  <= 1'b0;
                     owner_ff[k] <= req_ff.job;
                  end else if (CW'(k) == idx_ff + CW'(1)) begin
                     start_ff[k] <= cur_start_ff + req_ff.request_size[AW-1:0];
                     len_ff[k]   <= cur_len_ff - req_ff.request_size;
                     free_ff[k]  <= 1'b1;
                     owner_ff[k] <= '0;
                  end else if (k != 0 && CW'(k) > idx_ff + CW'(1) && CW'(k) <= count_ff) begin
                     start_ff[k] <= start_ff[KP];
                     len_ff[k]   <= len_ff[KP];
                     free_ff[k]  <= free_ff[KP];
                     owner_ff[k] <= owner_ff[KP];
                  end
               end
               ffsa_pkg::OP_MERGE: begin
                  if (CW'(k) == wr_idx) begin
                     len_ff[k] <= new_len;
                  end else if (CW'(k) + CW'(1) == count_ff) begin
                     start_ff[k] <= '0;
                     len_ff[k]   <= '0;
                     free_ff[k]  <= 1'b0;
                  end else if (CW'(k) >= rm_idx && CW'(k) + CW'(1) < count_ff) begin
                     start_ff[k] <= start_ff[KN];
                     len_ff[k]   <= len_ff[KN];
                     free_ff[k]  <= free_ff[KN];
                     owner_ff[k] <= owner_ff[KN];
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= CW'(NSEG))
      else $error("segment count out of range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready while an item is in progress");

   a_first_start_zero: assert property (@(posedge clock) disable iff (reset)
      start_ff[0] == '0)
      else $error("first segment does not start at zero");

   a_fail_no_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != ffsa_pkg::STATUS_OK |-> rsp_item.granted_start == '0)
      else $error("failed item carries a start address");
`endif

endmodule
